// ===== hw/rtl/gptmr_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer package
// Shared item kinds, register numbers and compare mode codes for the
// general-purpose timer and its channel logic.
// ----------------------------------------------------------------------------
package gptmr_pkg;

   // Kind of an input item.
   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // Compare modes of one channel.
   typedef enum logic [2:0] {
      MODE_FROZEN     = 3'd0,
      MODE_HIGH_MATCH = 3'd1,
      MODE_LOW_MATCH  = 3'd2,
      MODE_TOGGLE     = 3'd3,
      MODE_FORCE_LOW  = 3'd4,
      MODE_FORCE_HIGH = 3'd5,
      MODE_PWM        = 3'd6,
      MODE_PWM_INV    = 3'd7
   } mode_type;

   // Register numbers.
   localparam logic [3:0] REG_CTRL     = 4'd0;
   localparam logic [3:0] REG_IRQ_EN   = 4'd1;
   localparam logic [3:0] REG_STATUS   = 4'd2;
   localparam logic [3:0] REG_COUNT    = 4'd3;
   localparam logic [3:0] REG_PRESCALE = 4'd4;
   localparam logic [3:0] REG_RELOAD   = 4'd5;
   localparam logic [3:0] REG_MODE_A   = 4'd6;
   localparam logic [3:0] REG_MODE_B   = 4'd7;
   localparam logic [3:0] REG_OUT_EN   = 4'd8;
   localparam logic [3:0] REG_CMP_BASE = 4'd9;

   // Bit positions inside the control and mode registers.
   localparam int CTRL_EN_BIT  = 0;
   localparam int CTRL_OPM_BIT = 3;
   localparam int MODE_LO_POS  = 4;
   localparam int MODE_HI_POS  = 12;
   localparam int OUT_EN_STEP  = 4;

   localparam int MAX_CHANNELS = 4;
   localparam int REG_WIDTH    = 16;

endpackage

// ===== hw/rtl/gptmr_chan.sv =====
// ----------------------------------------------------------------------------
// Timer output channel
// Works out the next output level of one compare channel from its mode,
// its compare value and the main counter after the current item.
// ----------------------------------------------------------------------------
module gptmr_chan #(
   parameter int COUNTER_WIDTH = 16
) (
   input  gptmr_pkg::mode_type     mode,
   input  logic                    moved,
   input  logic [COUNTER_WIDTH-1:0] count,
   input  logic [COUNTER_WIDTH-1:0] compare,
   input  logic                    level,
   output logic                    level_next
);
   import gptmr_pkg::*;

   logic below;
   logic match;

   assign below = count < compare;
   // A match only counts right after a prescaled tick moved the counter.
   assign match = moved && (count == compare);

   always_comb begin
      case (mode)
         MODE_FROZEN:     level_next = level;
         MODE_HIGH_MATCH: level_next = match ? 1'b1 : level;
         MODE_LOW_MATCH:  level_next = match ? 1'b0 : level;
         MODE_TOGGLE:     level_next = match ? ~level : level;
         MODE_FORCE_LOW:  level_next = 1'b0;
         MODE_FORCE_HIGH: level_next = 1'b1;
         MODE_PWM:        level_next = below;
         MODE_PWM_INV:    level_next = ~below;
         default:         level_next = level;
      endcase
   end

endmodule

// ===== hw/rtl/general_purpose_timer_pwm_unit.sv =====
// ----------------------------------------------------------------------------
// General-purpose timer with output compare and PWM
// Up-counting timer with prescaler, reload, one-pulse mode and up to four
// compare channels, driven by a stream of tick, write and read items.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the req_ channel is a timer tick, a register write, a register
// read or a no-op. Every item produces exactly one result item on the rsp_
// channel with the read data, the update flag, the interrupt line, the
// enable bit and the gated channel pins as they stand after that item.
// An accepted item is captured in the input register, is applied to the
// timer state once the result register can advance, and appears in the
// result register. One item is taken per cycle while the receiver keeps up;
// the state update for an item is a single pass through the counter,
// register and compare logic. While the receiver stalls, the result
// register holds its item and the input register can still take one more
// item; after that req_tready drops until the result is taken. Reset
// (synchronous) empties both registers and returns the timer to stopped, count
// zero, reload all ones, all channels frozen with outputs low and disabled.
// ----------------------------------------------------------------------------
module general_purpose_timer_pwm_unit #(
   parameter int COUNTER_WIDTH = 16,
   parameter int CHANNEL_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] write_data
   input  logic [5:0]  req_tuser,  // [1:0] action, [5:2] reg_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] read_data, [16] update_flag, [17] irq, [18] running,
   // [22:19] channel_pins, [23] zero
   output logic [23:0] rsp_tdata
);
   import gptmr_pkg::*;

   localparam int CW = COUNTER_WIDTH;

   // Input register.
   logic             in_valid_ff, in_valid_in;
   action_type       in_action_ff;
   logic [3:0]       in_reg_ff;
   logic [15:0]      in_data_ff;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [23:0]      rsp_data_ff, rsp_data_in;

   // Timer state.
   logic [15:0]      pre_count_ff, pre_count_in;
   logic [15:0]      pre_value_ff, pre_value_in;
   logic [CW-1:0]    main_count_ff, main_count_in;
   logic [CW-1:0]    reload_ff, reload_in;
   logic             enable_ff, enable_in;
   logic             one_pulse_ff, one_pulse_in;
   logic             irq_en_ff, irq_en_in;
   logic             pending_ff, pending_in;
   mode_type         mode_ff [CHANNEL_COUNT];
   mode_type         mode_in [CHANNEL_COUNT];
   logic             chan_en_ff [CHANNEL_COUNT];
   logic             chan_en_in [CHANNEL_COUNT];
   logic [CW-1:0]    compare_ff [CHANNEL_COUNT];
   logic [CW-1:0]    compare_in [CHANNEL_COUNT];
   logic             level_ff [CHANNEL_COUNT];
   logic             level_in [CHANNEL_COUNT];

   logic             req_fire;
   logic             advance;
   logic             do_item;
   logic             moved;
   logic [15:0]      read_data;
   logic [3:0]       pins;
   logic [CW+15:0]   data_ext;
   logic [CW-1:0]    data_cnt;
   logic [CW+15:0]   count_ext;
   logic [CW+15:0]   reload_ext;
   logic [CW+15:0]   cmp_ext;
   logic             is_write;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign do_item    = in_valid_ff && advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign is_write   = (in_action_ff == ACT_WRITE);
   // Write data fitted to the counter width.
   assign data_ext   = {{CW{1'b0}}, in_data_ff};
   assign data_cnt   = data_ext[CW-1:0];
   assign count_ext  = {16'h0000, main_count_ff};
   assign reload_ext = {16'h0000, reload_ff};

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (do_item) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Tick and register writes.
   always_comb begin
      pre_count_in  = pre_count_ff;
      pre_value_in  = pre_value_ff;
      main_count_in = main_count_ff;
      reload_in     = reload_ff;
      enable_in     = enable_ff;
      one_pulse_in  = one_pulse_ff;
      irq_en_in     = irq_en_ff;
      pending_in    = pending_ff;
      moved         = 1'b0;
      for (int n = 0; n < CHANNEL_COUNT; n++) begin
         mode_in[n]    = mode_ff[n];
         chan_en_in[n] = chan_en_ff[n];
         compare_in[n] = compare_ff[n];
      end

      if (in_action_ff == ACT_TICK && enable_ff) begin
         if (pre_count_ff < pre_value_ff) begin
            pre_count_in = pre_count_ff + 16'd1;
         end else begin
            pre_count_in = '0;
            moved        = 1'b1;
            if (main_count_ff == reload_ff) begin
               main_count_in = '0;
               pending_in    = 1'b1;
               if (one_pulse_ff) begin
                  enable_in = 1'b0;
               end
            end else begin
               main_count_in = main_count_ff + {{(CW-1){1'b0}}, 1'b1};
            end
         end
      end

      if (is_write) begin
         case (in_reg_ff)
            REG_CTRL: begin
               enable_in    = in_data_ff[CTRL_EN_BIT];
               one_pulse_in = in_data_ff[CTRL_OPM_BIT];
            end
            REG_IRQ_EN:   irq_en_in     = in_data_ff[0];
            REG_STATUS:   pending_in    = pending_ff & in_data_ff[0];
            REG_COUNT:    main_count_in = data_cnt;
            REG_PRESCALE: pre_value_in  = in_data_ff;
            REG_RELOAD:   reload_in     = data_cnt;
            default: ;
         endcase
         for (int n = 0; n < CHANNEL_COUNT; n++) begin
            if ((in_reg_ff == REG_MODE_A && n < 2) || (in_reg_ff == REG_MODE_B && n >= 2)) begin
               if ((n % 2) == 0) begin
                  mode_in[n] = mode_type'(in_data_ff[MODE_LO_POS +: 3]);
               end else begin
                  mode_in[n] = mode_type'(in_data_ff[MODE_HI_POS +: 3]);
               end
            end
            if (in_reg_ff == REG_OUT_EN) begin
               chan_en_in[n] = in_data_ff[OUT_EN_STEP * n];
            end
            if (in_reg_ff == REG_CMP_BASE + 4'(n)) begin
               compare_in[n] = data_cnt;
            end
         end
      end
   end

   // Register reads see the state before the item; a read changes nothing.
   always_comb begin
      read_data = '0;
      cmp_ext   = '0;
      if (in_action_ff == ACT_READ) begin
         case (in_reg_ff)
            REG_CTRL: begin
               read_data[CTRL_EN_BIT]  = enable_ff;
               read_data[CTRL_OPM_BIT] = one_pulse_ff;
            end
            REG_IRQ_EN:   read_data[0] = irq_en_ff;
            REG_STATUS:   read_data[0] = pending_ff;
            REG_COUNT:    read_data    = count_ext[15:0];
            REG_PRESCALE: read_data    = pre_value_ff;
            REG_RELOAD:   read_data    = reload_ext[15:0];
            default: ;
         endcase
         for (int n = 0; n < CHANNEL_COUNT; n++) begin
            if ((in_reg_ff == REG_MODE_A && n < 2) || (in_reg_ff == REG_MODE_B && n >= 2)) begin
               if ((n % 2) == 0) begin
                  read_data[MODE_LO_POS +: 3] = mode_ff[n];
               end else begin
                  read_data[MODE_HI_POS +: 3] = mode_ff[n];
               end
            end
            if (in_reg_ff == REG_OUT_EN) begin
               read_data[OUT_EN_STEP * n] = chan_en_ff[n];
            end
            if (in_reg_ff == REG_CMP_BASE + 4'(n)) begin
               cmp_ext   = {16'h0000, compare_ff[n]};
               read_data = cmp_ext[15:0];
            end
         end
      end
   end

   for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_chan
      gptmr_chan #(
         .COUNTER_WIDTH(CW)
      ) u_chan (
         .mode       (mode_in[g]),
         .moved      (moved),
         .count      (main_count_in),
         .compare    (compare_in[g]),
         .level      (level_ff[g]),
         .level_next (level_in[g])
      );
   end

   always_comb begin
      pins = '0;
      for (int n = 0; n < CHANNEL_COUNT; n++) begin
         pins[n] = level_in[n] & chan_en_in[n];
      end
      rsp_data_in = {1'b0, pins, enable_in, pending_in & irq_en_in, pending_in, read_data};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pre_count_ff  <= '0;
         pre_value_ff  <= '0;
         main_count_ff <= '0;
         reload_ff     <= '1;
         enable_ff     <= 1'b0;
         one_pulse_ff  <= 1'b0;
         irq_en_ff     <= 1'b0;
         pending_ff    <= 1'b0;
         for (int n = 0; n < CHANNEL_COUNT; n++) begin
            mode_ff[n]    <= MODE_FROZEN;
            chan_en_ff[n] <= 1'b0;
            compare_ff[n] <= '0;
            level_ff[n]   <= 1'b0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (do_item) begin
            pre_count_ff  <= pre_count_in;
            pre_value_ff  <= pre_value_in;
            main_count_ff <= main_count_in;
            reload_ff     <= reload_in;
            enable_ff     <= enable_in;
            one_pulse_ff  <= one_pulse_in;
            irq_en_ff     <= irq_en_in;
            pending_ff    <= pending_in;
            for (int n = 0; n < CHANNEL_COUNT; n++) begin
               mode_ff[n]    <= mode_in[n];
               chan_en_ff[n] <= chan_en_in[n];
               compare_ff[n] <= compare_in[n];
               level_ff[n]   <= level_in[n];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_action_ff <= action_type'(req_tuser[1:0]);
         in_reg_ff    <= req_tuser[5:2];
         in_data_ff   <= req_tdata;
      end
      if (do_item) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
